@@ hw/rtl/load_cell_weight_kalman_core_assert.svh @@
// Assertion macros for the checker file of the load-cell weight core.
// Depends on nothing; included by the checker module.
`ifndef LOAD_CELL_WEIGHT_KALMAN_CORE_ASSERT_SVH
`define LOAD_CELL_WEIGHT_KALMAN_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCWK_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcwk assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LCWK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcwk assertion failed");

`endif

@@ hw/rtl/lcwk_pkg.sv @@
// Shared types and constants of the load-cell weight core.
// Depends on nothing; imported by the core and its checker.
package lcwk_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int WEIGHT_W      = 24;

  localparam int Q_W   = 16;
  localparam int R_W   = 17;
  localparam int DIV_W = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIVISOR = 2'd2;

  localparam logic [Q_W-1:0]         PROCESS_NOISE_RST = 16'd655;
  localparam logic [R_W-1:0]         MEASURE_NOISE_RST = 17'd32768;
  localparam logic [DIV_W-1:0]       SCALE_DIVISOR_RST = 16'd1;
  localparam logic [SAMPLE_BITS-1:0] TARE_LEVEL_RST    = SAMPLE_BITS'(8300692);

  typedef struct packed {
    logic                          mode;
    logic signed [SAMPLE_BITS-1:0] raw_sample;
  } in_word_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                object_present;
  } out_word_t;

endpackage

@@ hw/rtl/lcwk_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; used by the load-cell weight core for both of its divisions.
module lcwk_div #(
  parameter int SHIFT_W = 24,
  parameter int DEN_W   = 19,
  localparam int CNT_W  = $clog2(SHIFT_W + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DEN_W-1:0]   init_rem,
  input  logic [SHIFT_W-1:0] dividend,
  input  logic [DEN_W-1:0]   divisor,
  input  logic [CNT_W-1:0]   steps,
  output logic               done,
  output logic [SHIFT_W-1:0] quotient
);

  logic [DEN_W-1:0]   rem;
  logic [DEN_W-1:0]   den;
  logic [SHIFT_W-1:0] shreg;
  logic [SHIFT_W-1:0] quo;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [DEN_W:0]     trial;
  logic               take;

  // A zero divisor never subtracts, so the quotient comes out as zero.
  assign trial    = {rem, shreg[SHIFT_W-1]};
  assign take     = (den != '0) && (trial >= {1'b0, den});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= init_rem;
      shreg <= dividend;
      den   <= divisor;
      quo   <= '0;
    end else if (busy) begin
      rem   <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
      shreg <= shreg << 1;
      quo   <= {quo[SHIFT_W-2:0], take};
    end
  end

endmodule

@@ hw/rtl/lcwk_mul.sv @@
// Shift-add multiplier, one multiplier bit per cycle, giving floor(d * k / 2^(K_W-1)).
// Standalone; used by the load-cell weight core for the gain products.
module lcwk_mul #(
  parameter int D_W    = 40,
  parameter int K_W    = 17,
  localparam int CNT_W = $clog2(K_W + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [D_W-1:0] d,
  input  logic [K_W-1:0] k,
  output logic           done,
  output logic [D_W-1:0] result
);

  logic [D_W-1:0] acc;
  logic [D_W-1:0] dreg;
  logic [K_W-1:0] kreg;
  logic [K_W-1:0] lo;
  logic [CNT_W-1:0] cnt;
  logic           busy;
  logic [D_W:0]   sum;
  logic [D_W:0]   prod_top;

  // The partial sum is shifted right each step, so {acc, lo} ends as d * k.
  assign sum      = {1'b0, acc} + (kreg[0] ? {1'b0, dreg} : '0);
  assign prod_top = {acc, lo[K_W-1]};
  // The gain never exceeds one, so the product fits the width of d.
  assign result   = prod_top[D_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(K_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      dreg <= d;
      kreg <= k;
      lo   <= '0;
    end else if (busy) begin
      acc  <= sum[D_W:1];
      lo   <= {sum[0], lo[K_W-1:1]};
      kreg <= kreg >> 1;
    end
  end

endmodule

@@ hw/rtl/load_cell_weight_kalman_core.sv @@
// Top level of the load-cell weight core: tare, scaling and a scalar Kalman filter.
// Depends on lcwk_pkg, lcwk_div and lcwk_mul.
//
//   channel  signals                          direction  word
//   in       in_valid, in_ready, in_word      to core    in_word_t (mode, raw_sample)
//   out      out_valid, out_ready, out_word   from core  out_word_t (weight, object_present)
//   cfg      cfg_valid, cfg_ready, cfg_index,  to core    register index and write data
//            cfg_data
//
// A measure word at or below the tare passes from acceptance to result through the weight
// division, the gain division and the two gain products; tare words and samples above the
// tare go straight to the result. The serial divider works one bit per cycle and the serial
// multipliers one gain bit per cycle. The next word can be taken in the cycle in which the
// result appears, at the earliest.
// Reset is synchronous and restores the registers, the tare and the filter state.
// The core takes one word at a time; a finished result waits in the done state until the
// output register is free, and no new word is taken while it waits.
module load_cell_weight_kalman_core
  import lcwk_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Widths of the fixed-point datapath. The estimate carries the integer sample range
  // plus the fraction; the covariance is 2.FRAC_BITS; the gain never exceeds 1.0.
  localparam int SB      = SAMPLE_BITS;
  localparam int EST_W   = SB + FRAC_BITS;
  localparam int P_W     = FRAC_BITS + 2;
  localparam int PQ_W    = ((P_W > Q_W) ? P_W : Q_W) + 1;
  localparam int DEN_W   = ((P_W > R_W) ? P_W : R_W) + 1;
  localparam int K_W     = FRAC_BITS + 1;
  localparam int SHIFT_W = (SB > K_W) ? SB : K_W;
  localparam int CNT_W   = $clog2(SHIFT_W + 1);

  // Sequencer codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ZDIV = 3'd1;
  localparam logic [2:0] S_KDIV = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]       state;
  logic [Q_W-1:0]   process_noise;
  logic [R_W-1:0]   measure_noise;
  logic [DIV_W-1:0] scale_divisor;
  logic [SB-1:0]    tare_level;
  logic [EST_W-1:0] estimate;
  logic [P_W-1:0]   error_cov;
  logic [P_W-1:0]   pp;
  logic [SB-1:0]    z_int;
  logic             z_up;
  logic             zero_res;

  logic             in_acc;
  logic             out_free;
  logic [SB-1:0]    sample_ob;
  logic             above_tare;
  logic [SB-1:0]    tare_diff;
  logic [PQ_W-1:0]  pq_sum;
  logic [P_W-1:0]   pp_next;
  logic [DEN_W-1:0] den;
  logic [DIV_W-1:0] div_eff;
  logic [EST_W-1:0] z_fix;
  logic             z_ge;
  logic [EST_W-1:0] z_dist;
  logic [WEIGHT_W-1:0] res_weight;

  logic               div_k_sel;
  logic               div_start;
  logic [DEN_W-1:0]   div_rem;
  logic [SHIFT_W-1:0] div_dvd;
  logic [DEN_W-1:0]   div_dvs;
  logic [CNT_W-1:0]   div_steps;
  logic               div_done;
  logic [SHIFT_W-1:0] div_quo;

  logic             mul_start;
  logic             mul_a_done;
  logic             mul_b_done;
  logic             mul_done;
  logic [EST_W-1:0] mul_a_res;
  logic [P_W-1:0]   mul_b_res;

  assign in_ready  = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // Offset binary: flipping the sign bit maps the two's complement range onto 0..2^SB-1.
  assign sample_ob  = {~in_word.raw_sample[SB-1], in_word.raw_sample[SB-2:0]};
  assign above_tare = sample_ob > tare_level;
  assign tare_diff  = tare_level - sample_ob;

  // Predicted covariance P' = P + Q, saturated to the covariance width.
  assign pq_sum  = PQ_W'(error_cov) + PQ_W'(process_noise);
  assign pp_next = (pq_sum[PQ_W-1:P_W] != '0) ? '1 : pq_sum[P_W-1:0];
  assign den     = DEN_W'(pp) + DEN_W'(measure_noise);

  // A divisor of zero behaves as one.
  assign div_eff = (scale_divisor == '0) ? DIV_W'(1) : scale_divisor;

  // Innovation magnitude and direction, measured against the current estimate.
  assign z_fix  = {z_int, {FRAC_BITS{1'b0}}};
  assign z_ge   = z_fix >= estimate;
  assign z_dist = z_ge ? (z_fix - estimate) : (estimate - z_fix);

  assign res_weight = zero_res ? '0 : WEIGHT_W'(estimate[EST_W-1:FRAC_BITS]);

  // The one divider serves two jobs. First the weight quotient (tare - sample) / divisor,
  // one bit per sample bit. Then the gain K = P' * 2^F / (P' + R): the remainder is
  // preloaded with P' >> 1 and the low bit of P' is shifted in first, so the first step
  // compares P' itself against the denominator and yields the integer bit of K.
  assign div_k_sel = (state == S_ZDIV);
  assign div_start = (in_acc && !in_word.mode && !above_tare) || (div_k_sel && div_done);
  assign div_rem   = div_k_sel ? DEN_W'(pp >> 1) : '0;
  assign div_dvd   = div_k_sel ? (SHIFT_W'(pp[0]) << (SHIFT_W - 1))
                               : (SHIFT_W'(tare_diff) << (SHIFT_W - SB));
  assign div_dvs   = div_k_sel ? den : DEN_W'(div_eff);
  assign div_steps = div_k_sel ? CNT_W'(K_W) : CNT_W'(SB);

  assign mul_start = (state == S_KDIV) && div_done;
  assign mul_done  = mul_a_done && mul_b_done;

  lcwk_div #(
    .SHIFT_W (SHIFT_W),
    .DEN_W   (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .init_rem (div_rem),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .steps    (div_steps),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Both gain products run side by side: K * |z - X| for the estimate and K * P' for
  // the covariance.
  lcwk_mul #(
    .D_W (EST_W),
    .K_W (K_W)
  ) u_mul_est (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .d      (z_dist),
    .k      (div_quo[K_W-1:0]),
    .done   (mul_a_done),
    .result (mul_a_res)
  );

  lcwk_mul #(
    .D_W (P_W),
    .K_W (K_W)
  ) u_mul_cov (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .d      (pp),
    .k      (div_quo[K_W-1:0]),
    .done   (mul_b_done),
    .result (mul_b_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      process_noise <= PROCESS_NOISE_RST;
      measure_noise <= MEASURE_NOISE_RST;
      scale_divisor <= SCALE_DIVISOR_RST;
      tare_level    <= TARE_LEVEL_RST;
      estimate      <= '0;
      error_cov     <= P_W'(1) << FRAC_BITS;
      zero_res      <= 1'b1;
    end else begin
      // Register writes; an index past the list is dropped.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROCESS_NOISE: process_noise <= cfg_data[Q_W-1:0];
          REG_MEASURE_NOISE: measure_noise <= cfg_data[R_W-1:0];
          REG_SCALE_DIVISOR: scale_divisor <= cfg_data[DIV_W-1:0];
          default: ;
        endcase
      end

      // A taken result empties the output register unless the next one moves in.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (in_word.mode) begin
              tare_level <= sample_ob;
              zero_res   <= 1'b1;
              state      <= S_DONE;
            end else if (above_tare) begin
              // Lighter than the tare: report zero and leave the filter alone.
              zero_res <= 1'b1;
              state    <= S_DONE;
            end else begin
              zero_res <= 1'b0;
              pp       <= pp_next;
              state    <= S_ZDIV;
            end
          end
        end
        S_ZDIV: begin
          if (div_done) begin
            z_int <= div_quo[SB-1:0];
            state <= S_KDIV;
          end
        end
        S_KDIV: begin
          if (div_done) begin
            z_up  <= z_ge;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          // The correction is truncated toward zero, so X moves toward z but never past it.
          if (mul_done) begin
            estimate  <= z_up ? (estimate + mul_a_res) : (estimate - mul_a_res);
            error_cov <= pp - mul_b_res;
            state     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result word; loaded only when the output register is free.
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_word.weight         <= res_weight;
      out_word.object_present <= (res_weight != '0);
    end
  end

endmodule

@@ hw/rtl/lcwk_checker.sv @@
// Port-level checker for the load-cell weight core, bound to the top level.
// Depends on lcwk_pkg and the assertion macros header.
`include "load_cell_weight_kalman_core_assert.svh"

module lcwk_checker
  import lcwk_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input in_word_t              in_word,
  input logic                  out_valid,
  input logic                  out_ready,
  input out_word_t             out_word,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // A waiting result keeps its word until it is taken.
  `LCWK_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_word))

  // The presence flag always agrees with the weight it travels with.
  `LCWK_ASSERT_SAME(a_present, clk, rst, out_valid, out_word.object_present == (out_word.weight != '0))

  // One word at a time: the core is busy right after it takes a word.
  `LCWK_ASSERT_NEXT(a_one_word, clk, rst, in_valid && in_ready, !in_ready)

  // Nothing is offered on the output right after reset.
  `LCWK_ASSERT_SAME(a_reset_quiet, clk, rst, $past(rst), !out_valid)

endmodule

bind load_cell_weight_kalman_core lcwk_checker u_lcwk_checker (.*);
